[sv/text_console_cursor_engine_core_assert.svh]
// assertion macros for the text console cursor engine
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TTCE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ttce assertion failed");
`define TTCE_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("ttce forbidden condition seen");
`else
`define TTCE_ASSERT(label, prop)
`define TTCE_NEVER(label, cond)
`endif

`endif

[sv/ttce_pkg.sv]
// shared types and constants for the text console cursor engine
package ttce_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLUMNS = 128;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
    localparam int TAB_STOP    = 8;

    localparam int ROWS_W = 6;
    localparam int COLS_W = 8;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd25;
    localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;

    localparam logic [IDX_W-1:0] CFG_ROWS        = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COLS        = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ORIGIN_X    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ORIGIN_Y    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TEXT_COLOUR = 3'd4;

    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [7:0] CODE_NL    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] SPACE_CODE = 8'h20;

    localparam logic [1:0] ACT_MOVE  = 2'd0;
    localparam logic [1:0] ACT_GLYPH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_BAD   = 2'd3;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        KIND_BS,
        KIND_TAB,
        KIND_NL,
        KIND_CR,
        KIND_PRINT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic [ROWS_W-1:0] rows;
        logic [COLS_W-1:0] cols;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_INIT   = 3'b001,
        ST_RUN    = 3'b010,
        ST_SCROLL = 3'b100
    } t_state;

endpackage

[sv/ttce_front.sv]
// front end: takes input words and classifies the character code
module ttce_front import ttce_pkg::*; (
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_fifo_full,
    input  logic       i_init_busy,
    output t_push      o_push
);

    t_kind kind;

    always_comb begin
        unique case (i_s_tdata)
            CODE_BS:  kind = KIND_BS;
            CODE_TAB: kind = KIND_TAB;
            CODE_NL:  kind = KIND_NL;
            CODE_CR:  kind = KIND_CR;
            default:  kind = KIND_PRINT;
        endcase
    end

    // no words taken while the store is still being blanked after reset
    assign o_s_tready        = !i_fifo_full && !i_init_busy;
    assign o_push.valid      = i_s_tvalid && o_s_tready;
    assign o_push.entry.kind = kind;
    assign o_push.entry.code = i_s_tdata;

endmodule

[sv/ttce_fifo.sv]
// small queue of classified characters between front and back end
module ttce_fifo import ttce_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    t_entry                 r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [FIFO_PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [FIFO_PW:0]       r_count, n_count;

    assign o_full  = (r_count == (FIFO_PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PW'(FIFO_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PW'(FIFO_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

[sv/ttce_back.sv]
// back end: cursor update, text store writes, scroll clearing and result word
module ttce_back import ttce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_init_busy,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata
);

`include "text_console_cursor_engine_core_assert.svh"

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [ROW_W-1:0]   r_clr_row, n_clr_row;
    logic [COL_W:0]     r_clr_cnt, n_clr_cnt;
    logic [ADDR_W-1:0]  r_init_cnt, n_init_cnt;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_action, n_action;

    logic [7:0]         r_store [CELLS];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_data;

    logic [ROWS_W-1:0]  rows_eff;
    logic [COLS_W-1:0]  cols_eff;
    logic [COL_W-1:0]   col_c;
    logic [ROW_W-1:0]   row_c;
    logic [COLS_W-1:0]  col_next;
    logic [ROWS_W-1:0]  row_next;
    logic [COL_W-1:0]   col_wr;
    logic [1:0]         action;
    logic               scroll;
    logic [ROW_W-1:0]   phys_row;

    // zero acts as one, oversized values act as the maximum
    always_comb begin
        if (i_cfg.rows == '0) begin
            rows_eff = ROWS_W'(1);
        end else if (i_cfg.rows > ROWS_W'(MAX_ROWS)) begin
            rows_eff = ROWS_W'(MAX_ROWS);
        end else begin
            rows_eff = i_cfg.rows;
        end
        if (i_cfg.cols == '0) begin
            cols_eff = COLS_W'(1);
        end else if (i_cfg.cols > COLS_W'(MAX_COLUMNS)) begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end else begin
            cols_eff = i_cfg.cols;
        end
    end

    // cursor is pulled back inside the box if the box has shrunk
    assign col_c = (COLS_W'(r_col) >= cols_eff) ? COL_W'(cols_eff - 1'b1) : r_col;
    assign row_c = (ROWS_W'(r_row) >= rows_eff) ? ROW_W'(rows_eff - 1'b1) : r_row;

    always_comb begin
        col_next = COLS_W'(col_c);
        row_next = ROWS_W'(row_c);
        col_wr   = col_c;
        action   = ACT_MOVE;
        unique case (i_entry.kind)
            KIND_BS: begin
                if (col_c != '0) begin
                    col_next = COLS_W'(col_c) - 1'b1;
                    col_wr   = col_c - 1'b1;
                end
                action = ACT_CLEAR;
            end
            KIND_TAB: begin
                col_next = (COLS_W'(col_c) + COLS_W'(TAB_STOP)) & ~COLS_W'(TAB_STOP - 1);
                if (col_next >= cols_eff) begin
                    col_next = '0;
                    row_next = ROWS_W'(row_c) + 1'b1;
                end
            end
            KIND_NL: begin
                col_next = '0;
                row_next = ROWS_W'(row_c) + 1'b1;
            end
            KIND_CR: begin
                col_next = '0;
            end
            KIND_PRINT: begin
                action   = ACT_GLYPH;
                col_next = COLS_W'(col_c) + 1'b1;
                if (col_next >= cols_eff) begin
                    col_next = '0;
                    row_next = ROWS_W'(row_c) + 1'b1;
                end
            end
            default: begin
                action = ACT_MOVE;
            end
        endcase
    end

    assign scroll   = (row_next >= rows_eff);
    assign phys_row = r_top + row_c;

    assign o_pop = (r_state == ST_RUN) && !i_empty && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_top       = r_top;
        n_clr_row   = r_clr_row;
        n_clr_cnt   = r_clr_cnt;
        n_init_cnt  = r_init_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_action    = r_action;
        mem_we      = 1'b0;
        mem_addr    = {phys_row, col_wr};
        mem_data    = SPACE_CODE;
        unique case (r_state)
            ST_INIT: begin
                mem_we     = 1'b1;
                mem_addr   = r_init_cnt;
                n_init_cnt = r_init_cnt + 1'b1;
                if (r_init_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_pop) begin
                    n_out_valid = 1'b1;
                    n_action    = action;
                    mem_we      = (i_entry.kind == KIND_BS) || (i_entry.kind == KIND_PRINT);
                    mem_data    = (i_entry.kind == KIND_PRINT) ? i_entry.code : SPACE_CODE;
                    n_col       = COL_W'(col_next);
                    if (scroll) begin
                        n_top     = r_top + 1'b1;
                        n_row     = ROW_W'(rows_eff - 1'b1);
                        // new bottom row sits at top + rows after the pointer moves
                        n_clr_row = ROW_W'(ROWS_W'(r_top) + rows_eff);
                        n_clr_cnt = '0;
                        n_state   = ST_SCROLL;
                    end else begin
                        n_row = ROW_W'(row_next);
                    end
                end
            end
            ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_addr  = {r_clr_row, r_clr_cnt[COL_W-1:0]};
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == (COL_W+1)'(MAX_COLUMNS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_clr_cnt   <= '0;
            r_init_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_top       <= n_top;
            r_clr_cnt   <= n_clr_cnt;
            r_init_cnt  <= n_init_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr_row <= n_clr_row;
        r_action  <= n_action;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= mem_data;
        end
    end

    assign o_init_busy = (r_state == ST_INIT);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {6'b0, r_action};

    `TTCE_ASSERT(a_state_onehot, $onehot(r_state))
    `TTCE_ASSERT(a_scroll_enters_clear, (o_pop && scroll) |=> (r_state == ST_SCROLL) && (r_clr_cnt == '0))
    `TTCE_ASSERT(a_init_done, (r_state == ST_INIT) && (r_init_cnt == ADDR_W'(CELLS - 1)) |=> (r_state == ST_RUN))
    `TTCE_NEVER(a_no_bad_action, r_out_valid && (r_action == ACT_BAD))

endmodule

[sv/text_console_cursor_engine_core.sv]
// one word in, one word out; the back end stalls while its result word is not taken
// a word that scrolls holds the back end while it blanks every cell of the new bottom row
// one word per cycle unless scrolling or stalled, set by the single store write port
// reset: synchronous active low; afterwards the store is blanked one cell a cycle
// through MAX_ROWS * MAX_COLUMNS (4096) cells with s_tready low, config writes still taken
// rows_in_use resets to 25, columns_in_use to 80, cursor and top row to zero
module text_console_cursor_engine_core import ttce_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] char_code
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // [1:0] action, [7:2] zero
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [ROWS_W-1:0] r_rows;
    logic [COLS_W-1:0] r_cols;
    t_cfg              cfg;
    t_push             push;
    t_entry            entry;
    logic              fifo_full;
    logic              fifo_empty;
    logic              pop;
    logic              init_busy;

    // origin and colour only matter to pixel drawing, which lives elsewhere
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS:        r_rows <= i_cfg_data[ROWS_W-1:0];
                CFG_COLS:        r_cols <= i_cfg_data[COLS_W-1:0];
                CFG_ORIGIN_X,
                CFG_ORIGIN_Y,
                CFG_TEXT_COLOUR: r_rows <= r_rows;
                default:         r_cols <= r_cols;
            endcase
        end
    end

    assign cfg.rows = r_rows;
    assign cfg.cols = r_cols;

    ttce_front u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_fifo_full (fifo_full),
        .i_init_busy (init_busy),
        .o_push      (push)
    );

    ttce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_empty (fifo_empty),
        .o_entry (entry)
    );

    ttce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (fifo_empty),
        .i_entry     (entry),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

[sim/text_console_cursor_engine_core_tb.sv]
// self-checking testbench for the text console cursor engine core
`timescale 1ns / 1ps

module text_console_cursor_engine_core_tb;
    import ttce_pkg::*;

    localparam int ORIGIN_W    = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = MAX_COLUMNS + 32;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 70;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [7:0]       s_tdata = '0;
    logic             m_tready = 1'b0;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [7:0]       o_m_tdata;

    text_console_cursor_engine_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [7:0] char_code
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // [1:0] action, [7:2] zero
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // stimulus and expected results
    logic [7:0] pending_codes[$];
    logic [1:0] expected_actions[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         err_count = 0;
    int         cycles = 0;

    // console state as the block should hold it
    logic [ROWS_W-1:0]   rows_reg = ROWS_RESET;
    logic [COLS_W-1:0]   cols_reg = COLS_RESET;
    logic [ORIGIN_W-1:0] origin_x = '0;
    logic [ORIGIN_W-1:0] origin_y = '0;
    logic [23:0]         colour = 24'hFFFFFF;
    int unsigned         cur_col = 0;
    int unsigned         cur_row = 0;
    int unsigned         top_row = 0;
    logic [7:0]          screen[CELLS];

    function automatic int unsigned cell_at(input int unsigned row, input int unsigned col);
        return ((top_row + row) % MAX_ROWS) * MAX_COLUMNS + (col % MAX_COLUMNS);
    endfunction

    // advance the console by one character and return the action it causes
    function automatic logic [1:0] console_apply(input logic [7:0] code);
        int unsigned rows;
        int unsigned cols;
        int unsigned base;
        logic [1:0]  act;
        rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : cols_reg;
        act = ACT_MOVE;
        // box may have shrunk under the cursor
        if (cur_col >= cols) cur_col = cols - 1;
        if (cur_row >= rows) cur_row = rows - 1;
        case (code)
            CODE_BS: begin
                if (cur_col != 0) cur_col--;
                screen[cell_at(cur_row, cur_col)] = SPACE_CODE;
                act = ACT_CLEAR;
            end
            CODE_TAB: begin
                cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
                if (cur_col >= cols) begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            CODE_NL: begin
                cur_col = 0;
                cur_row++;
            end
            CODE_CR: cur_col = 0;
            default: begin
                screen[cell_at(cur_row, cur_col)] = code;
                act = ACT_GLYPH;
                cur_col++;
                if (cur_col >= cols) begin
                    cur_col = 0;
                    cur_row++;
                end
            end
        endcase
        if (cur_row >= rows) begin
            top_row = (top_row + 1) % MAX_ROWS;
            cur_row = rows - 1;
            base = cell_at(cur_row, 0);
            for (int i = 0; i < MAX_COLUMNS; i++) screen[base + i] = SPACE_CODE;
        end
        return act;
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 12) return CODE_NL;
        if (r < 22) return CODE_BS;
        if (r < 32) return CODE_TAB;
        if (r < 38) return CODE_CR;
        if (r < 75) return 8'($urandom_range(8'h21, 8'h7E));
        return 8'($urandom);
    endfunction

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // driver: one word per handshake, gaps at random
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready)
                expected_actions.push_back(console_apply(s_tdata));
            if (!s_tvalid || o_s_tready) begin
                if (pending_codes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_codes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, checks each result word against the oldest expectation
    always @(posedge clk) begin
        logic [1:0] want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (expected_actions.size() == 0) begin
                    $error("unexpected word: action %0d", o_m_tdata[1:0]);
                    err_count++;
                end else begin
                    want = expected_actions.pop_front();
                    if (o_m_tdata[1:0] !== want) begin
                        $error("action: expected %0d, got %0d", want, o_m_tdata[1:0]);
                        err_count++;
                    end
                    if (o_m_tdata[7:2] !== 6'd0) begin
                        $error("padding: expected 0, got %0h", o_m_tdata[7:2]);
                        err_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_ROWS:        rows_reg = val[ROWS_W-1:0];
            CFG_COLS:        cols_reg = val[COLS_W-1:0];
            CFG_ORIGIN_X:    origin_x = val[ORIGIN_W-1:0];
            CFG_ORIGIN_Y:    origin_y = val[ORIGIN_W-1:0];
            CFG_TEXT_COLOUR: colour = val[23:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // upper data bits above each register are filled with noise
    task automatic set_geometry(input int rows, input int cols, input int ox, input int oy,
                                input int rgb);
        cfg_write(CFG_ROWS, (CFG_W'($urandom) << ROWS_W) | CFG_W'(rows));
        cfg_write(CFG_COLS, (CFG_W'($urandom) << COLS_W) | CFG_W'(cols));
        cfg_write(CFG_ORIGIN_X, (CFG_W'($urandom) << ORIGIN_W) | CFG_W'(ox));
        cfg_write(CFG_ORIGIN_Y, (CFG_W'($urandom) << ORIGIN_W) | CFG_W'(oy));
        cfg_write(CFG_TEXT_COLOUR, CFG_W'(rgb));
    endtask

    // all words accepted and answered, then let a scroll blanking pass finish
    // checked on the falling edge so driver and monitor updates have settled
    task automatic drain();
        @(negedge clk);
        while (pending_codes.size() != 0 || s_tvalid || expected_actions.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) pending_codes.push_back(pick_code());
    endtask

    initial begin
        int rows_tab[PHASES] = '{1, 32, 0, 63, 5, 17, 3, 40};
        int cols_tab[PHASES] = '{1, 128, 0, 255, 9, 100, 7, 200};
        int send_tab[4] = '{0, 72, 0, 26};
        int recv_tab[4] = '{0, 0, 72, 26};
        for (int i = 0; i < CELLS; i++) screen[i] = SPACE_CODE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry first
        push_random(40);
        drain();

        // small box so wraps and scrolls come quickly
        set_geometry(2, 10, 0, 0, 0);
        pending_codes.push_back(CODE_BS);           // backspace at the cursor left by the last run
        pending_codes.push_back(8'h41);
        pending_codes.push_back(8'h00);
        pending_codes.push_back(8'hFF);
        pending_codes.push_back(8'h7F);
        pending_codes.push_back(CODE_CR);
        pending_codes.push_back(CODE_TAB);
        pending_codes.push_back(CODE_TAB);          // tab past the last column wraps
        pending_codes.push_back(8'h42);
        pending_codes.push_back(CODE_BS);
        pending_codes.push_back(CODE_BS);
        pending_codes.push_back(CODE_NL);           // below last row, scrolls
        pending_codes.push_back(8'h0B);
        pending_codes.push_back(8'h0C);
        pending_codes.push_back(8'h0E);
        pending_codes.push_back(8'h07);
        for (int i = 0; i < 10; i++) pending_codes.push_back(8'h61 + 8'(i));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                for (int idx = CFG_TEXT_COLOUR + 1; idx < (1 << IDX_W); idx++)
                    cfg_write(IDX_W'(idx), CFG_W'($urandom));
            end
            if (p == 1)
                set_geometry(rows_tab[p], cols_tab[p], 4095, 4095, 24'hFFFFFF);
            else
                set_geometry(rows_tab[p], cols_tab[p], $urandom_range(4095),
                             $urandom_range(4095), $urandom_range(24'hFFFFFF));
            send_idle_pct  = send_tab[p % 4];
            recv_stall_pct = recv_tab[p % 4];
            push_random(PHASE_WORDS);
            drain();
        end

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
